// ===== hw/rtl/paged_shelf_region_allocator_macros.svh =====
// assertion helpers for the shelf allocator
`ifndef PAGED_SHELF_REGION_ALLOCATOR_MACROS_SVH
`define PAGED_SHELF_REGION_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PSRA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/psra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psra_pkg;

  localparam int MAX_PAGES_DEF = 8;
  localparam int DIM_W = 15;
  localparam int POS_W = 14;
  localparam int CY_W = 17;
  localparam int SUM_W = 18;

  localparam logic [DIM_W-1:0] SIDE_RESET = 15'd8192;
  localparam logic [DIM_W-1:0] SIDE_LIMIT = 15'd16384;
  localparam logic PAD = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [2:0]       page_index;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [3:0]       pages_open;
  } rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic [DIM_W-1:0] rh;
  } page_rec_t;

  typedef struct packed {
    logic      en;
    page_rec_t rec;
  } mem_wr_t;

  typedef struct packed {
    logic [CY_W-1:0]  a;
    logic [DIM_W-1:0] b;
    logic             cin;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CHK_X,
    ST_WRAP,
    ST_CHK_Y,
    ST_ADV,
    ST_NEXT,
    ST_OPEN,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psra_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psra_alu (
  input  psra_pkg::alu_req_t        req,
  input  logic [psra_pkg::DIM_W-1:0] side,
  output psra_pkg::alu_rsp_t        rsp
);
  import psra_pkg::*;

  logic [SUM_W-1:0] sum;

  // shared adder with compare against the page side
  assign sum = SUM_W'(req.a) + SUM_W'(req.b) + SUM_W'(req.cin);
  assign rsp.sum = sum;
  assign rsp.gt = sum > SUM_W'(side);

endmodule

`default_nettype wire

// ===== hw/rtl/psra_page_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psra_page_mem #(
  parameter int MAX_PAGES = psra_pkg::MAX_PAGES_DEF,
  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic                clk,
  input  psra_pkg::mem_wr_t   wr,
  input  logic [PW-1:0]       wr_addr,
  input  logic                rd_en,
  input  logic [PW-1:0]       rd_addr,
  output psra_pkg::page_rec_t rd_data
);
  import psra_pkg::*;

  page_rec_t mem [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/psra_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "paged_shelf_region_allocator_macros.svh"

module psra_seq #(
  parameter int MAX_PAGES = psra_pkg::MAX_PAGES_DEF,
  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1,
  localparam int CW = $clog2(MAX_PAGES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [psra_pkg::DIM_W-1:0] side,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  psra_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output psra_pkg::rsp_t             rsp,
  output psra_pkg::alu_req_t         alu_req,
  input  psra_pkg::alu_rsp_t         alu_rsp,
  output psra_pkg::mem_wr_t          wr,
  output logic [PW-1:0]              wr_addr,
  output logic                       rd_en,
  output logic [PW-1:0]              rd_addr,
  input  psra_pkg::page_rec_t        rd_data
);
  import psra_pkg::*;

  state_t state;
  state_t state_next;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [DIM_W-1:0] cx;
  logic [CY_W-1:0]  cy;
  logic [DIM_W-1:0] rh;
  logic [PW-1:0]    p;
  logic [CW-1:0]    pages_used;

  logic             accept;
  logic             size_ok;
  logic             more_pages;
  logic             can_open;
  logic [PW+2:0]    pg_ext;
  logic [CW+3:0]    cnt_ext;
  logic [2:0]       pg_idx;
  logic [3:0]       open_cnt;

  assign accept = req_valid && !req_stall;
  assign size_ok = (req.rect_width != '0) && (req.rect_height != '0) &&
                   (req.rect_width <= side) && (req.rect_height <= side);
  assign more_pages = (CW'(p) + CW'(1)) < pages_used;
  assign can_open = pages_used < CW'(MAX_PAGES);

  assign pg_ext = {3'b000, p};
  assign cnt_ext = {4'b0000, pages_used};
  assign pg_idx = pg_ext[2:0];
  assign open_cnt = cnt_ext[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_RELEASE || !size_ok) begin
            state_next = ST_RESP;
          end else if (pages_used == '0) begin
            state_next = ST_OPEN;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_CHK_X;
      ST_CHK_X: state_next = alu_rsp.gt ? ST_WRAP : ST_CHK_Y;
      ST_WRAP:  state_next = ST_CHK_Y;
      ST_CHK_Y: state_next = alu_rsp.gt ? ST_NEXT : ST_ADV;
      ST_ADV:   state_next = ST_RESP;
      ST_NEXT: begin
        if (more_pages) begin
          state_next = ST_READ;
        end else if (can_open) begin
          state_next = ST_OPEN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_OPEN:  state_next = ST_CHK_X;
      ST_RESP:  state_next = rsp_stall ? ST_RESP : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = state != ST_IDLE;
    rsp_valid = state == ST_RESP;
    rd_en = state == ST_READ;
    rd_addr = p;
    wr_addr = p;
    wr.en = state == ST_ADV;
    wr.rec.cx = alu_rsp.sum[DIM_W-1:0];
    wr.rec.cy = cy[DIM_W-1:0];
    wr.rec.rh = (h > rh) ? h : rh;
    alu_req.a = CY_W'(cx);
    alu_req.b = w;
    alu_req.cin = 1'b0;
    case (state)
      ST_WRAP: begin
        alu_req.a = cy;
        alu_req.b = rh;
        alu_req.cin = PAD;
      end
      ST_CHK_Y: begin
        alu_req.a = cy;
        alu_req.b = h;
      end
      ST_ADV: begin
        alu_req.cin = PAD;
      end
      default: begin
        alu_req.cin = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_used <= '0;
      p <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            p <= '0;
            if (req.mode == MODE_RELEASE) begin
              pages_used <= '0;
            end
          end
        end
        ST_NEXT: begin
          if (more_pages) begin
            p <= p + PW'(1);
          end
        end
        ST_OPEN: begin
          p <= pages_used[PW-1:0];
          pages_used <= pages_used + CW'(1);
        end
        default: begin
          p <= p;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          w <= req.rect_width;
          h <= req.rect_height;
          rsp.ok <= req.mode == MODE_RELEASE;
          rsp.page_index <= '0;
          rsp.x_pos <= '0;
          rsp.y_pos <= '0;
          rsp.pages_open <= (req.mode == MODE_RELEASE) ? 4'd0 : open_cnt;
        end
      end
      ST_LOAD: begin
        cx <= rd_data.cx;
        cy <= CY_W'(rd_data.cy);
        rh <= rd_data.rh;
      end
      ST_CHK_X: begin
        if (alu_rsp.gt) begin
          cx <= '0;
        end
      end
      ST_WRAP: begin
        cy <= alu_rsp.sum[CY_W-1:0];
        rh <= '0;
      end
      ST_ADV: begin
        rsp.ok <= 1'b1;
        rsp.page_index <= pg_idx;
        rsp.x_pos <= cx[POS_W-1:0];
        rsp.y_pos <= cy[POS_W-1:0];
        rsp.pages_open <= open_cnt;
      end
      ST_NEXT: begin
        rsp.ok <= 1'b0;
        rsp.page_index <= '0;
        rsp.x_pos <= '0;
        rsp.y_pos <= '0;
        rsp.pages_open <= open_cnt;
      end
      ST_OPEN: begin
        cx <= '0;
        cy <= '0;
        rh <= '0;
      end
      default: begin
        cx <= cx;
      end
    endcase
  end

  `PSRA_ASSERT_IMPL(a_hold_result, clk, rst, rsp_valid, req_stall,
                    "new transaction taken while a result waits")
  `PSRA_ASSERT_NEXT(a_write_then_result, clk, rst, wr.en, rsp_valid && rsp.ok,
                    "page record written without a successful result")
  `PSRA_ASSERT_IMPL(a_write_open_page, clk, rst, wr.en, CW'(wr_addr) < pages_used,
                    "page record written beyond the open pages")
  `PSRA_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, pages_used <= CW'(MAX_PAGES),
                    "open page count above the page limit")
  `PSRA_ASSERT_NEXT(a_release, clk, rst, accept && req.mode == MODE_RELEASE,
                    rsp_valid && rsp.ok && pages_used == '0,
                    "release did not close all pages")

endmodule

`default_nettype wire

// ===== hw/rtl/paged_shelf_region_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shelf allocator for rectangles on up to MAX_PAGES square pages of side page_side (reset
// 8192, values above 16384 act as 16384). An allocation tries the open pages in order and
// places the rectangle on the first that fits, wrapping to a new row one pixel below the
// tallest item of the current row; failing that it opens a fresh page if one is left.
// One transaction is worked at a time and req_stall stays high until the result is taken.
// A release or a refused size goes from the accept straight to the result. An allocation
// works through each open page it examines with a record read, load, x check, optional
// row wrap, y check, then advance or move on; a page it opens is checked the same way from
// the x check on. The single adder-comparator and the one read port of the page record
// memory serialise these steps. Configuration writes are always accepted; the user must
// make them only while idle, as the block itself does not enforce it.
module paged_shelf_region_allocator #(
  parameter int MAX_PAGES = psra_pkg::MAX_PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [psra_pkg::DIM_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  psra_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output psra_pkg::rsp_t             rsp
);
  import psra_pkg::*;

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  logic [DIM_W-1:0] page_side;
  logic [DIM_W-1:0] side;

  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  mem_wr_t   wr;
  logic [PW-1:0] wr_addr;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  page_rec_t     rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_side <= SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      page_side <= cfg_data;
    end
  end

  assign side = (page_side > SIDE_LIMIT) ? SIDE_LIMIT : page_side;

  psra_seq #(
    .MAX_PAGES(MAX_PAGES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .side     (side),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .alu_req  (alu_req),
    .alu_rsp  (alu_rsp),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  psra_alu u_alu (
    .req (alu_req),
    .side(side),
    .rsp (alu_rsp)
  );

  psra_page_mem #(
    .MAX_PAGES(MAX_PAGES)
  ) u_mem (
    .clk    (clk),
    .wr     (wr),
    .wr_addr(wr_addr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_paged_shelf_region_allocator.sv =====
`timescale 1ns / 1ps

module tb_paged_shelf_region_allocator;
  import psra_pkg::*;

  localparam int PAGES = MAX_PAGES_DEF;
  localparam int unsigned SIDE_CAP = 16384;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_SHOWN = 10;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [DIM_W-1:0] cfg_data;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;

  // shadow copy of the allocator state
  logic [DIM_W-1:0] shelf_side;
  int unsigned      shelf_pages;
  logic [DIM_W-1:0] shelf_cx [PAGES];
  logic [DIM_W-1:0] shelf_cy [PAGES];
  logic [DIM_W-1:0] shelf_rh [PAGES];

  rsp_t pending_placements [$];

  bit idling_on;
  bit hold_request;
  int mismatches;
  int n_placed;
  int n_refused;
  int n_releases;
  int n_side_writes;

  paged_shelf_region_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("paged_shelf_region_allocator: mismatch");
    $finish;
  end

  function automatic int unsigned eff_side();
    return (32'(shelf_side) > SIDE_CAP) ? SIDE_CAP : 32'(shelf_side);
  endfunction

  function automatic bit place_on_page(int p, int unsigned w, int unsigned h,
                                       int unsigned side, output int unsigned ox,
                                       output int unsigned oy);
    int unsigned cx;
    int unsigned cy;
    int unsigned rh;
    cx = 32'(shelf_cx[p]);
    cy = 32'(shelf_cy[p]);
    rh = 32'(shelf_rh[p]);
    ox = 0;
    oy = 0;
    if (cx + w > side) begin
      cx = 0;
      cy = cy + rh + 1;
      rh = 0;
    end
    if (cy + h > side) return 1'b0;
    ox = cx;
    oy = cy;
    shelf_cx[p] = DIM_W'(cx + w + 1);
    shelf_cy[p] = DIM_W'(cy);
    if (h > rh) rh = h;
    shelf_rh[p] = DIM_W'(rh);
    return 1'b1;
  endfunction

  function automatic rsp_t predict_placement(req_t r);
    rsp_t        o;
    int unsigned w;
    int unsigned h;
    int unsigned side;
    int unsigned x;
    int unsigned y;
    int unsigned pg;
    int          p;
    bit          ok;
    o = '0;
    if (r.mode == MODE_RELEASE) begin
      shelf_pages = 0;
      o.ok = 1'b1;
      n_releases++;
      return o;
    end
    w = 32'(r.rect_width);
    h = 32'(r.rect_height);
    side = eff_side();
    ok = 1'b0;
    pg = 0;
    x = 0;
    y = 0;
    if (w != 0 && h != 0 && w <= side && h <= side) begin
      for (p = 0; p < int'(shelf_pages) && !ok; p++) begin
        if (place_on_page(p, w, h, side, x, y)) begin
          ok = 1'b1;
          pg = p;
        end
      end
      if (!ok && shelf_pages < PAGES) begin
        p = shelf_pages;
        shelf_cx[p] = '0;
        shelf_cy[p] = '0;
        shelf_rh[p] = '0;
        shelf_pages++;
        if (place_on_page(p, w, h, side, x, y)) begin
          ok = 1'b1;
          pg = p;
        end
      end
    end
    if (ok) begin
      o.ok = 1'b1;
      o.page_index = pg[2:0];
      o.x_pos = x[POS_W-1:0];
      o.y_pos = y[POS_W-1:0];
      n_placed++;
    end else begin
      n_refused++;
    end
    o.pages_open = shelf_pages[3:0];
    return o;
  endfunction

  function automatic req_t make_request(logic m, int unsigned w, int unsigned h);
    req_t r;
    r.mode = m;
    r.rect_width = w[DIM_W-1:0];
    r.rect_height = h[DIM_W-1:0];
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned side;
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    int          k;
    side = eff_side();
    k = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    if (k < 3) begin
      r = make_request(MODE_RELEASE, a, b);
    end else if (k < 6) begin
      if ($urandom_range(0, 1)) r = make_request(MODE_ALLOC, 0, b);
      else r = make_request(MODE_ALLOC, a, 0);
    end else if (k < 10) begin
      r = make_request(MODE_ALLOC, a, b);
    end else if (k < 14 && side < 32767) begin
      lim = (side == 0) ? 1 : side;
      if ($urandom_range(0, 1))
        r = make_request(MODE_ALLOC, $urandom_range(side + 1, 32767), $urandom_range(1, lim));
      else
        r = make_request(MODE_ALLOC, $urandom_range(1, lim), $urandom_range(side + 1, 32767));
    end else begin
      lim = side >> $urandom_range(1, 4);
      if (lim == 0) lim = 1;
      a = $urandom_range(1, lim);
      b = $urandom_range(1, lim);
      if (side != 0 && $urandom_range(0, 19) == 0) a = side;
      if (side != 0 && $urandom_range(0, 19) == 0) b = side;
      r = make_request(MODE_ALLOC, a, b);
    end
    return r;
  endfunction

  task automatic send_request(req_t item);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req = item;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    pending_placements.insert(pending_placements.size(), predict_placement(item));
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_placements.size() != 0) @(negedge clk);
  endtask

  task automatic set_page_side(int unsigned value);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value[DIM_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    shelf_side = value[DIM_W-1:0];
    n_side_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_size_checks();
    send_request(make_request(MODE_ALLOC, 0, 5));
    send_request(make_request(MODE_ALLOC, 5, 0));
    send_request(make_request(MODE_ALLOC, 8193, 1));
    send_request(make_request(MODE_ALLOC, 1, 8193));
    send_request(make_request(MODE_ALLOC, 32767, 32767));
  endtask

  task automatic test_row_wrap_and_release();
    send_request(make_request(MODE_ALLOC, 8192, 8192));
    send_request(make_request(MODE_ALLOC, 1, 1));
    send_request(make_request(MODE_ALLOC, 100, 50));
    send_request(make_request(MODE_ALLOC, 8000, 10));
    send_request(make_request(MODE_RELEASE, 32767, 32767));
    send_request(make_request(MODE_ALLOC, 1, 1));
  endtask

  task automatic test_all_pages_full();
    set_page_side(1);
    repeat (PAGES + 1) send_request(make_request(MODE_ALLOC, 1, 1));
    send_request(make_request(MODE_ALLOC, 2, 1));
    send_request(make_request(MODE_RELEASE, 0, 0));
  endtask

  task automatic test_side_extremes();
    set_page_side(0);
    send_request(make_request(MODE_ALLOC, 1, 1));
    set_page_side(32767);
    send_request(make_request(MODE_ALLOC, 16384, 16384));
    send_request(make_request(MODE_ALLOC, 16384, 1));
    send_request(make_request(MODE_ALLOC, 16385, 1));
    set_page_side(16384);
    send_request(make_request(MODE_RELEASE, 0, 0));
    send_request(make_request(MODE_ALLOC, 16384, 16384));
  endtask

  task automatic test_random_shelves(int unsigned side, int count);
    set_page_side(side);
    repeat (count) begin
      send_request(random_request());
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  task automatic test_long_hold();
    set_page_side(64);
    hold_request = 1'b1;
    repeat (30) send_request(random_request());
  endtask

  task automatic test_drain_pause();
    repeat (10) send_request(random_request());
    drain_results();
    repeat (10) send_request(random_request());
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    set_page_side(8192);
    repeat (70) send_request(random_request());
  endtask

  // response checker
  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_placements.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: unexpected transaction ok=%0d page=%0d x=%0d y=%0d open=%0d",
                     $realtime, rsp.ok, rsp.page_index, rsp.x_pos, rsp.y_pos, rsp.pages_open);
        end else begin
          want = pending_placements.pop_front();
          if (rsp.ok !== want.ok || rsp.page_index !== want.page_index ||
              rsp.x_pos !== want.x_pos || rsp.y_pos !== want.y_pos ||
              rsp.pages_open !== want.pages_open) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("%0t: expected ok=%0d page=%0d x=%0d y=%0d open=%0d",
                       $realtime, want.ok, want.page_index, want.x_pos, want.y_pos,
                       want.pages_open);
              $display("%0t:      got ok=%0d page=%0d x=%0d y=%0d open=%0d",
                       $realtime, rsp.ok, rsp.page_index, rsp.x_pos, rsp.y_pos,
                       rsp.pages_open);
            end
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_stall = 1'b0;
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        rsp_stall = 1'b0;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    idling_on = 1'b1;
    hold_request = 1'b0;
    mismatches = 0;
    n_placed = 0;
    n_refused = 0;
    n_releases = 0;
    n_side_writes = 0;
    shelf_side = SIDE_RESET;
    shelf_pages = 0;
    for (int i = 0; i < PAGES; i++) begin
      shelf_cx[i] = '0;
      shelf_cy[i] = '0;
      shelf_rh[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_size_checks();
    test_row_wrap_and_release();
    test_all_pages_full();
    test_side_extremes();
    test_random_shelves(8192, 60);
    test_random_shelves(40, 60);
    test_random_shelves(7, 60);
    test_random_shelves(16384, 60);
    test_random_shelves(1, 50);
    test_random_shelves(32767, 60);
    test_random_shelves(0, 30);
    test_random_shelves(300, 60);
    test_long_hold();
    test_drain_pause();
    test_steady_stream();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d placements, %0d refused requests and %0d releases",
             n_placed, n_refused, n_releases);
    $display("over %0d page side settings, with %0d mismatching transactions",
             n_side_writes, mismatches);
    if (mismatches == 0) begin
      $display("paged_shelf_region_allocator: match");
    end else begin
      $display("paged_shelf_region_allocator: mismatch");
    end
    $finish;
  end

endmodule
